// ===== rtl/core/iir_df1_pkg.sv =====
// Shared types, widths and a helper function of the direct form I IIR filter.
`default_nettype none

package iir_df1_pkg;

  localparam int MAX_TAPS       = 5;
  localparam int SAMPLE_WIDTH   = 16;
  localparam int COEF_FRAC_BITS = 12;

  localparam int HIST_DEPTH = MAX_TAPS - 1;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = SAMPLE_WIDTH + COEF_W;
  localparam int TERM_W     = PROD_W + 1;
  localparam int ACC_W      = PROD_W + $clog2(2 * MAX_TAPS) + 1;
  localparam int RND_W      = ACC_W - COEF_FRAC_BITS;

  localparam int CFG_TAPS_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int FF_LOW_N   = CFG_DATA_W / COEF_W;
  localparam int FB_N       = CFG_DATA_W / COEF_W;
  localparam int TAP_W      = $clog2(MAX_TAPS + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FF_TAPS     = 3'd0,
    REG_FB_TAPS     = 3'd1,
    REG_FF_COEF_LOW = 3'd2,
    REG_FF_COEF_HI  = 3'd3,
    REG_FB_COEF     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic advance;
    logic ff_en;
    logic fb_en;
  } tap_ctrl_t;

  function automatic logic [TAP_W-1:0] clamp_taps(input logic [CFG_TAPS_W-1:0] taps);
    logic [TAP_W-1:0] res;
    if (taps == '0) begin
      res = TAP_W'(1);
    end else if (int'(taps) > MAX_TAPS) begin
      res = TAP_W'(MAX_TAPS);
    end else begin
      res = TAP_W'(taps);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/iir_direct_form_one_filter.sv =====
// Direct form I IIR filter built as a row of delay cells.
//
// Input channel in_valid/in_ready carries one signed 16-bit sample per transaction.
// Output channel out_valid/out_ready carries the filtered sample and a saturation flag.
// Configuration: write cfg_wdata to register cfg_index while cfg_we is high; index 0
// feedforward tap count, 1 feedback tap count, 2 b0..b3, 3 b4, 4 a1..a4 (Q4.12).
// Writes to other indexes are dropped. Write only while no transaction is in flight.
// The result of an accepted sample is registered in the output stage at the accepting
// edge, so out_valid rises in the cycle after acceptance.
// Throughput: one sample per cycle while the output register is free. Each cycle forms all products of the current
// sample and the four held samples of each history, sums them, rounds and saturates;
// the result is needed by the next sample's feedback, so this combinational loop sets it.
// Reset: both histories clear to zero, coefficients return to a unity pass-through.
// Stall: while a result waits and out_ready is low, in_ready is low and the histories
// hold; the output register frees as soon as the held transaction is taken.
`default_nettype none

module iir_direct_form_one_filter
  import iir_df1_pkg::*;
(
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [CFG_DATA_W-1:0]          cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      out_sample_out,
  output logic                                out_clipped
);

  logic [CFG_TAPS_W-1:0] ff_taps_r, ff_taps_nxt;
  logic [CFG_TAPS_W-1:0] fb_taps_r, fb_taps_nxt;
  logic [CFG_DATA_W-1:0] ff_low_r, ff_low_nxt;
  logic [COEF_W-1:0]     ff_high_r, ff_high_nxt;
  logic [CFG_DATA_W-1:0] fb_coef_r, fb_coef_nxt;

  logic [TAP_W-1:0]               nf;
  logic [TAP_W-1:0]               nb;
  logic                           accept;
  logic                           slot_free;
  logic signed [SAMPLE_WIDTH-1:0] y_new;
  logic signed [COEF_W-1:0]       b0;
  logic signed [PROD_W-1:0]       p0;
  logic signed [ACC_W-1:0]        acc;

  logic signed [SAMPLE_WIDTH-1:0] x_chain [0:HIST_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] y_chain [0:HIST_DEPTH];
  logic signed [TERM_W-1:0]       term    [1:HIST_DEPTH];

  always_comb begin
    ff_taps_nxt = ff_taps_r;
    fb_taps_nxt = fb_taps_r;
    ff_low_nxt  = ff_low_r;
    ff_high_nxt = ff_high_r;
    fb_coef_nxt = fb_coef_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FF_TAPS:     ff_taps_nxt = cfg_wdata[CFG_TAPS_W-1:0];
        REG_FB_TAPS:     fb_taps_nxt = cfg_wdata[CFG_TAPS_W-1:0];
        REG_FF_COEF_LOW: ff_low_nxt  = cfg_wdata;
        REG_FF_COEF_HI:  ff_high_nxt = cfg_wdata[COEF_W-1:0];
        REG_FB_COEF:     fb_coef_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_taps_r <= CFG_TAPS_W'(1);
      fb_taps_r <= CFG_TAPS_W'(1);
      ff_low_r  <= CFG_DATA_W'(1) << COEF_FRAC_BITS;
      ff_high_r <= '0;
      fb_coef_r <= '0;
    end else begin
      ff_taps_r <= ff_taps_nxt;
      fb_taps_r <= fb_taps_nxt;
      ff_low_r  <= ff_low_nxt;
      ff_high_r <= ff_high_nxt;
      fb_coef_r <= fb_coef_nxt;
    end
  end

  assign nf = clamp_taps(ff_taps_r);
  assign nb = clamp_taps(fb_taps_r);

  assign in_ready = slot_free;
  assign accept   = in_valid && in_ready;

  assign x_chain[0] = in_sample_in;
  assign y_chain[0] = y_new;

  genvar k;
  generate
    for (k = 1; k <= HIST_DEPTH; k++) begin : g_tap
      logic signed [COEF_W-1:0] cb;
      logic signed [COEF_W-1:0] ca;
      tap_ctrl_t                ctrl;

      if (k < FF_LOW_N) begin : g_b_low
        assign cb = ff_low_r[k*COEF_W +: COEF_W];
      end else if (k == FF_LOW_N) begin : g_b_high
        assign cb = ff_high_r;
      end else begin : g_b_zero
        assign cb = '0;
      end

      if (k <= FB_N) begin : g_a_reg
        assign ca = fb_coef_r[(k-1)*COEF_W +: COEF_W];
      end else begin : g_a_zero
        assign ca = '0;
      end

      assign ctrl.advance = accept;
      assign ctrl.ff_en   = TAP_W'(k) < nf;
      assign ctrl.fb_en   = TAP_W'(k) < nb;

      iir_df1_tap u_tap (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .coef_b (cb),
        .coef_a (ca),
        .x_prev (x_chain[k-1]),
        .y_prev (y_chain[k-1]),
        .x_hold (x_chain[k]),
        .y_hold (y_chain[k]),
        .term   (term[k])
      );
    end
  endgenerate

  assign b0 = ff_low_r[COEF_W-1:0];
  assign p0 = b0 * in_sample_in;

  always_comb begin
    acc = {{(ACC_W-PROD_W){p0[PROD_W-1]}}, p0};
    for (int i = 1; i <= HIST_DEPTH; i++) begin
      acc = acc + {{(ACC_W-TERM_W){term[i][TERM_W-1]}}, term[i]};
    end
  end

  iir_df1_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (accept),
    .acc         (acc),
    .out_ready   (out_ready),
    .slot_free   (slot_free),
    .y_new       (y_new),
    .out_valid   (out_valid),
    .out_sample  (out_sample_out),
    .out_clipped (out_clipped)
  );

endmodule

`default_nettype wire

// ===== rtl/core/iir_df1_tap.sv =====
// One delay cell of the filter: holds x[n-k] and y[n-k] and forms its weighted term.
`default_nettype none

module iir_df1_tap
  import iir_df1_pkg::*;
(
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire tap_ctrl_t                       ctrl,
  input  wire logic signed [COEF_W-1:0]        coef_b,
  input  wire logic signed [COEF_W-1:0]        coef_a,
  input  wire logic signed [SAMPLE_WIDTH-1:0]  x_prev,
  input  wire logic signed [SAMPLE_WIDTH-1:0]  y_prev,
  output logic signed [SAMPLE_WIDTH-1:0]       x_hold,
  output logic signed [SAMPLE_WIDTH-1:0]       y_hold,
  output logic signed [TERM_W-1:0]             term
);

  logic signed [SAMPLE_WIDTH-1:0] x_r, x_nxt;
  logic signed [SAMPLE_WIDTH-1:0] y_r, y_nxt;
  logic signed [PROD_W-1:0]       ff_prod;
  logic signed [PROD_W-1:0]       fb_prod;
  logic signed [TERM_W-1:0]       ff_term;
  logic signed [TERM_W-1:0]       fb_term;

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (ctrl.advance) begin
      x_nxt = x_prev;
      y_nxt = y_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
    end else begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  assign ff_prod = coef_b * x_r;
  assign fb_prod = coef_a * y_r;
  assign ff_term = ctrl.ff_en ? {ff_prod[PROD_W-1], ff_prod} : '0;
  assign fb_term = ctrl.fb_en ? {fb_prod[PROD_W-1], fb_prod} : '0;
  assign term    = ff_term - fb_term;

  assign x_hold = x_r;
  assign y_hold = y_r;

endmodule

`default_nettype wire

// ===== rtl/core/iir_df1_out.sv =====
// Output stage: round, saturate and hold the result transaction.
`default_nettype none

module iir_df1_out
  import iir_df1_pkg::*;
(
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            load,
  input  wire logic signed [ACC_W-1:0]         acc,
  input  wire logic                            out_ready,
  output logic                                 slot_free,
  output logic signed [SAMPLE_WIDTH-1:0]       y_new,
  output logic                                 out_valid,
  output logic signed [SAMPLE_WIDTH-1:0]       out_sample,
  output logic                                 out_clipped
);

  localparam logic signed [RND_W-1:0] SAT_MAX =
    RND_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [RND_W-1:0] SAT_MIN = -SAT_MAX - RND_W'(1);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

  logic signed [ACC_W-1:0]        acc_rnd;
  logic signed [RND_W-1:0]        shifted;
  logic                           clip_new;
  logic                           valid_r, valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] sample_r, sample_nxt;
  logic                           clip_r, clip_nxt;

  assign acc_rnd = acc + RND_HALF;
  assign shifted = acc_rnd[ACC_W-1:COEF_FRAC_BITS];

  always_comb begin
    clip_new = 1'b0;
    y_new    = shifted[SAMPLE_WIDTH-1:0];
    if (shifted > SAT_MAX) begin
      y_new    = SAT_MAX[SAMPLE_WIDTH-1:0];
      clip_new = 1'b1;
    end else if (shifted < SAT_MIN) begin
      y_new    = SAT_MIN[SAMPLE_WIDTH-1:0];
      clip_new = 1'b1;
    end
  end

  assign slot_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt  = valid_r;
    sample_nxt = sample_r;
    clip_nxt   = clip_r;
    if (load) begin
      valid_nxt  = 1'b1;
      sample_nxt = y_new;
      clip_nxt   = clip_new;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    clip_r   <= clip_nxt;
  end

  assign out_valid   = valid_r;
  assign out_sample  = sample_r;
  assign out_clipped = clip_r;

  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> slot_free)
    else $error("result loaded while a stalled transaction is held");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> valid_r)
    else $error("loaded result not presented");

  a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && clip_r) |-> (sample_r == SAT_MAX[SAMPLE_WIDTH-1:0] ||
                             sample_r == SAT_MIN[SAMPLE_WIDTH-1:0]))
    else $error("clipped result not at a saturation rail");

  a_unclipped_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !clip_new) |-> (shifted <= SAT_MAX && shifted >= SAT_MIN))
    else $error("out-of-range result not flagged as clipped");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench of the direct form I IIR filter with valid/ready channels.
module tb
  import iir_df1_pkg::*;
();

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;
  localparam int                   STALL_MAX       = 18;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    sample_t sample;
    logic    clipped;
  } filtered_t;

  logic                  clk;
  logic                  rst_n          = 1'b0;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata      = '0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  sample_t               in_sample_in   = '0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  sample_t               out_sample_out;
  logic                  out_clipped;

  // filter settings and delay lines as seen by the predictor
  logic [CFG_TAPS_W-1:0] ff_taps_q;
  logic [CFG_TAPS_W-1:0] fb_taps_q;
  logic [63:0]           ff_coef_low_q;
  logic [15:0]           ff_coef_high_q;
  logic [63:0]           fb_coef_q;
  sample_t               x_delay [HIST_DEPTH];
  sample_t               y_delay [HIST_DEPTH];

  sample_t     samples_to_send [$];
  filtered_t   expected_out [$];
  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  int unsigned in_gap_left  = 0;
  int unsigned out_gap_left = 0;
  int unsigned n_errors     = 0;

  iir_direct_form_one_filter i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb NOT OK");
    $finish;
  end

  function automatic int unsigned taps_used(input logic [CFG_TAPS_W-1:0] t);
    int unsigned n;
    n = 32'(t);
    if (n < 1) n = 1;
    if (n > MAX_TAPS) n = MAX_TAPS;
    return n;
  endfunction

  function automatic sample_t ff_coef(input int unsigned k);
    sample_t c;
    c = '0;
    if (k < 4) c = ff_coef_low_q[16*k +: 16];
    else if (k == 4) c = ff_coef_high_q;
    return c;
  endfunction

  function automatic sample_t fb_coef(input int unsigned k);
    sample_t c;
    c = '0;
    if (k >= 1 && k <= 4) c = fb_coef_q[16*(k-1) +: 16];
    return c;
  endfunction

  // compute one output sample and advance both delay lines
  function automatic filtered_t filter_sample(input sample_t x);
    int unsigned nf;
    int unsigned nb;
    longint      acc;
    longint      y;
    longint      maxv;
    filtered_t   r;
    nf   = taps_used(ff_taps_q);
    nb   = taps_used(fb_taps_q);
    maxv = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
    acc  = longint'(ff_coef(0)) * longint'(x);
    for (int k = 1; k < MAX_TAPS; k++) begin
      if (k < nf) acc += longint'(ff_coef(k)) * longint'(x_delay[k-1]);
      if (k < nb) acc -= longint'(fb_coef(k)) * longint'(y_delay[k-1]);
    end
    acc += longint'(1) << (COEF_FRAC_BITS - 1);
    y = acc >>> COEF_FRAC_BITS;
    r.clipped = 1'b0;
    if (y > maxv) begin
      y = maxv;
      r.clipped = 1'b1;
    end
    if (y < -maxv - 1) begin
      y = -maxv - 1;
      r.clipped = 1'b1;
    end
    r.sample = sample_t'(y);
    for (int k = HIST_DEPTH - 1; k > 0; k--) begin
      x_delay[k] = x_delay[k-1];
      y_delay[k] = y_delay[k-1];
    end
    x_delay[0] = x;
    y_delay[0] = r.sample;
    return r;
  endfunction

  function automatic sample_t pick_sample();
    sample_t s;
    case ($urandom_range(9))
      0: s = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      1: s = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      2, 3: begin
        s = sample_t'($urandom_range(512));
        s = s - 16'sd256;
      end
      default: s = sample_t'($urandom);
    endcase
    return s;
  endfunction

  function automatic logic [15:0] pick_coef(input bit tame);
    logic [15:0] c;
    case ($urandom_range(7))
      0: c = 16'h7FFF;
      1: c = 16'h8000;
      2: c = '0;
      3: c = 16'($urandom);
      default: begin
        c = 16'($urandom_range(8192));
        c = c - 16'd4096;
      end
    endcase
    if (tame && $urandom_range(3) != 0) begin
      c = 16'($urandom_range(1024));
      c = c - 16'd512;
    end
    return c;
  endfunction

  // driver: present queued samples, predict on each accepted transaction
  always @(posedge clk) begin
    logic    fire;
    logic    nxt_valid;
    sample_t nxt_sample;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      fire       = in_valid && in_ready;
      nxt_valid  = 1'b0;
      nxt_sample = in_sample_in;
      if (fire) expected_out = {expected_out, filter_sample(in_sample_in)};
      if (!in_valid || fire) begin
        if (in_gap_left > 0) begin
          in_gap_left--;
        end else if (samples_to_send.size() > 0) begin
          if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
            in_gap_left = $urandom_range(STALL_MAX - 1);
          end else begin
            nxt_valid  = 1'b1;
            nxt_sample = samples_to_send.pop_front();
          end
        end
        in_valid     <= nxt_valid;
        in_sample_in <= nxt_sample;
      end
    end
  end

  // monitor: check each result transaction against the oldest prediction
  always @(posedge clk) begin
    filtered_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_out.size() == 0) begin
          n_errors++;
          if (n_errors < 100)
            $display("%0t: unexpected result, expected none, got sample %0d clipped %0b",
                     $time, out_sample_out, out_clipped);
        end else begin
          e = expected_out.pop_front();
          if (out_sample_out !== e.sample) begin
            n_errors++;
            if (n_errors < 100)
              $display("%0t: sample_out expected %0d got %0d", $time, e.sample, out_sample_out);
          end
          if (out_clipped !== e.clipped) begin
            n_errors++;
            if (n_errors < 100)
              $display("%0t: clipped expected %0b got %0b", $time, e.clipped, out_clipped);
          end
        end
      end
      if (out_gap_left > 0) begin
        out_gap_left--;
        out_ready <= 1'b0;
      end else if (out_idle_pct != 0 && $urandom_range(99) < out_idle_pct) begin
        out_gap_left = $urandom_range(STALL_MAX - 1);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // hold until every queued sample has gone through and every result is in
  task automatic drain();
    @(negedge clk);
    while (samples_to_send.size() != 0 || in_valid || expected_out.size() != 0)
      @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    case (idx)
      REG_FF_TAPS:     ff_taps_q      = d[CFG_TAPS_W-1:0];
      REG_FB_TAPS:     fb_taps_q      = d[CFG_TAPS_W-1:0];
      REG_FF_COEF_LOW: ff_coef_low_q  = d;
      REG_FF_COEF_HI:  ff_coef_high_q = d[15:0];
      REG_FB_COEF:     fb_coef_q      = d;
      default: ;
    endcase
  endtask

  task automatic cfg_close();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    logic [63:0] ff_low;
    logic [63:0] fb;
    for (int k = 0; k < 4; k++) begin
      ff_low[16*k +: 16] = pick_coef(1'b0);
      fb[16*k +: 16]     = pick_coef(1'b1);
    end
    cfg_write(REG_FF_TAPS, {$urandom, $urandom});
    cfg_write(REG_FB_TAPS, {$urandom, $urandom});
    cfg_write(REG_FF_COEF_LOW, ff_low);
    cfg_write(REG_FF_COEF_HI, {$urandom, $urandom});
    cfg_write(REG_FB_COEF, fb);
    if ($urandom_range(3) == 0)
      cfg_write(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), {$urandom, $urandom});
    cfg_close();
  endtask

  initial begin
    ff_taps_q      = 3'd1;
    fb_taps_q      = 3'd1;
    ff_coef_low_q  = 64'd4096;
    ff_coef_high_q = '0;
    fb_coef_q      = '0;
    for (int k = 0; k < HIST_DEPTH; k++) begin
      x_delay[k] = '0;
      y_delay[k] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings pass the input straight through
    samples_to_send = '{16'sh7FFF, -16'sh8000, 16'sd0, 16'sd1, -16'sd1};
    drain();

    // all feedforward taps at the largest coefficient, saturate both ways
    cfg_write(REG_FF_TAPS, 64'd5);
    cfg_write(REG_FB_TAPS, 64'd5);
    cfg_write(REG_FF_COEF_LOW, {4{16'h7FFF}});
    cfg_write(REG_FF_COEF_HI, 64'h7FFF);
    cfg_write(REG_FB_COEF, '0);
    cfg_close();
    samples_to_send = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, -16'sh8000};
    drain();

    // most negative coefficients everywhere, tap counts above the limit
    cfg_write(REG_FF_TAPS, 64'd7);
    cfg_write(REG_FB_TAPS, 64'd6);
    cfg_write(REG_FF_COEF_LOW, {4{16'h8000}});
    cfg_write(REG_FF_COEF_HI, 64'hFFFF_FFFF_FFFF_8000);
    cfg_write(REG_FB_COEF, {4{16'h8000}});
    cfg_close();
    samples_to_send = '{16'sh7FFF, -16'sh8000, 16'sd1, 16'sd0};
    drain();

    // zero tap counts, half gain for rounding ties, writes past the register list
    cfg_write(REG_FF_TAPS, 64'd0);
    cfg_write(REG_FB_TAPS, 64'd0);
    cfg_write(REG_FF_COEF_LOW, {48'hFFFF_1234_8001, 16'h0800});
    cfg_write(REG_SPARE_FIRST, '1);
    cfg_write(REG_SPARE_LAST, {$urandom, $urandom});
    cfg_write(REG_SPARE_FIRST + 3'd1, {$urandom, $urandom});
    cfg_close();
    samples_to_send = '{16'sd1, -16'sd1, 16'sd3, -16'sd3, 16'sh7FFF, -16'sh8000};
    drain();

    // integrator: feedback of minus one drives the output into both rails
    cfg_write(REG_FF_TAPS, 64'd1);
    cfg_write(REG_FF_COEF_LOW, 64'd4096);
    cfg_write(REG_FB_TAPS, 64'd2);
    cfg_write(REG_FB_COEF, 64'h0000_0000_0000_F000);
    cfg_close();
    samples_to_send = '{16'sd20000, 16'sd20000, -16'sh8000, -16'sh8000};
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      random_config();
      case ($urandom_range(3))
        0: in_idle_pct = 0;
        1: in_idle_pct = 10;
        2: in_idle_pct = 30;
        default: in_idle_pct = 60;
      endcase
      case ($urandom_range(3))
        0: out_idle_pct = 0;
        1: out_idle_pct = 10;
        2: out_idle_pct = 30;
        default: out_idle_pct = 60;
      endcase
      if (phase == 9) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      repeat (125) samples_to_send = {samples_to_send, pick_sample()};
      drain();
    end

    repeat (4) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
